/* design/pcae_pkg.sv */
// shared types, codes and defaults for the point cloud angle extremes block
`timescale 1ns / 1ps
`default_nettype none

package pcae_pkg;

  // default coordinate width in bits
  localparam int unsigned COORD_BITS_DEF = 16;

  // multiplier operand pairs
  localparam logic [2:0] MUL_PY_LZ = 3'd0;
  localparam logic [2:0] MUL_PZ_LY = 3'd1;
  localparam logic [2:0] MUL_HY_PZ = 3'd2;
  localparam logic [2:0] MUL_HZ_PY = 3'd3;
  localparam logic [2:0] MUL_SQ_X  = 3'd4;
  localparam logic [2:0] MUL_SQ_Y  = 3'd5;
  localparam logic [2:0] MUL_SQ_Z  = 3'd6;

  // product slots
  localparam logic [1:0] SLOT_0 = 2'd0;
  localparam logic [1:0] SLOT_1 = 2'd1;
  localparam logic [1:0] SLOT_2 = 2'd2;
  localparam logic [1:0] SLOT_3 = 2'd3;

  // angle classes, ordered by angle
  localparam logic [1:0] ANG_NEG  = 2'd0;
  localparam logic [1:0] ANG_ZERO = 2'd1;
  localparam logic [1:0] ANG_POS  = 2'd2;
  localparam logic [1:0] ANG_PI   = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic       load_point;
    logic       mul_en;
    logic [2:0] mul_op;
    logic [1:0] mul_slot;
    logic       decide;
    logic       sum_first;
    logic       sum_next;
    logic       root_start;
    logic       out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
    logic root_busy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* design/pcae_isqrt.sv */
// iterative floor square root, one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pcae_isqrt #(
  parameter int unsigned ROOT_BITS = 18
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [2*ROOT_BITS-1:0]   radicand_i,
  output logic                          busy_o,
  output logic [ROOT_BITS-1:0]          root_o
);

  localparam int unsigned RW = ROOT_BITS + 3;
  localparam int unsigned CW = $clog2(ROOT_BITS);
  localparam logic [CW-1:0] CNT_LAST = CW'(ROOT_BITS - 1);

  logic                   busy_q, busy_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [2*ROOT_BITS-1:0] rad_q, rad_d;
  logic [RW-1:0]          rem_q, rem_d;
  logic [ROOT_BITS-1:0]   root_q, root_d;
  logic [RW-1:0]          rem_sh;
  logic [RW-1:0]          trial;

  // one restoring step
  assign rem_sh = {rem_q[RW-3:0], rad_q[2*ROOT_BITS-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_LAST;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[2*ROOT_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_BITS-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("square root started while busy");
  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && (cnt_q == CNT_LAST))
    else $error("square root did not load its count");
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (cnt_q == '0) && !start_i |=> !busy_q)
    else $error("square root ran past its last step");
`endif

endmodule

`default_nettype wire

/* design/pcae_dp.sv */
// datapath: point and extreme registers, shared multiplier, sums, output register
`timescale 1ns / 1ps
`default_nettype none

module pcae_dp
  import pcae_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cmd_t                         cmd_i,
  output status_t                           status_o,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic signed [COORD_BITS-1:0] point_z_i,
  input  wire logic                         last_point_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0]      center_x_o,
  output logic signed [COORD_BITS-1:0]      center_y_o,
  output logic signed [COORD_BITS-1:0]      center_z_o,
  output logic [COORD_BITS:0]               height_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned OW = C + 1;       // multiplier operand width
  localparam int unsigned PW = 2 * C + 2;   // product width
  localparam int unsigned NR = C + 2;       // root bits
  localparam int unsigned AW = 2 * NR;      // sum of squares width

  logic signed [C-1:0] px_q, py_q, pz_q;
  logic                last_q;
  logic signed [C-1:0] lo_q [3];
  logic signed [C-1:0] hi_q [3];
  logic                started_q;
  logic signed [PW-1:0] cp_q [4];
  logic [AW-1:0]        acc_q;
  logic                 out_valid_q;
  logic signed [C-1:0]  cx_q, cy_q, cz_q;
  logic [C:0]           height_q;

  logic signed [OW-1:0] dx, dy, dz;
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic [1:0]           cls_p, cls_lo, cls_hi;
  logic                 less_lo, less_hi;
  logic signed [C:0]    sum_x, sum_y, sum_z;
  logic                 root_busy;
  logic [NR-1:0]        root;
  logic                 out_free;

  // angle class of (y, z)
  function automatic logic [1:0] ang_class(input logic signed [C-1:0] y,
                                           input logic signed [C-1:0] z);
    logic [1:0] c;
    if (z[C-1]) begin
      c = ANG_NEG;
    end else if (z != '0) begin
      c = ANG_POS;
    end else if (!y[C-1]) begin
      c = ANG_ZERO;
    end else begin
      c = ANG_PI;
    end
    return c;
  endfunction

  // exact angle order from classes and cross products
  function automatic logic ang_less(input logic [1:0] ca, input logic [1:0] cb,
                                    input logic cross_gt);
    logic r;
    if (ca != cb) begin
      r = (ca < cb);
    end else if ((ca == ANG_ZERO) || (ca == ANG_PI)) begin
      r = 1'b0;
    end else begin
      r = cross_gt;
    end
    return r;
  endfunction

  // coordinate differences between the extremes
  assign dx = {lo_q[0][C-1], lo_q[0]} - {hi_q[0][C-1], hi_q[0]};
  assign dy = {lo_q[1][C-1], lo_q[1]} - {hi_q[1][C-1], hi_q[1]};
  assign dz = {lo_q[2][C-1], lo_q[2]} - {hi_q[2][C-1], hi_q[2]};

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_op)
      MUL_PY_LZ: begin
        mul_a = {py_q[C-1], py_q};
        mul_b = {lo_q[2][C-1], lo_q[2]};
      end
      MUL_PZ_LY: begin
        mul_a = {pz_q[C-1], pz_q};
        mul_b = {lo_q[1][C-1], lo_q[1]};
      end
      MUL_HY_PZ: begin
        mul_a = {hi_q[1][C-1], hi_q[1]};
        mul_b = {pz_q[C-1], pz_q};
      end
      MUL_HZ_PY: begin
        mul_a = {hi_q[2][C-1], hi_q[2]};
        mul_b = {py_q[C-1], py_q};
      end
      MUL_SQ_X: begin
        mul_a = dx;
        mul_b = dx;
      end
      MUL_SQ_Y: begin
        mul_a = dy;
        mul_b = dy;
      end
      MUL_SQ_Z: begin
        mul_a = dz;
        mul_b = dz;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // comparisons against the stored extremes
  assign cls_p   = ang_class(py_q, pz_q);
  assign cls_lo  = ang_class(lo_q[1], lo_q[2]);
  assign cls_hi  = ang_class(hi_q[1], hi_q[2]);
  assign less_lo = ang_less(cls_p, cls_lo, cp_q[0] > cp_q[1]);
  assign less_hi = ang_less(cls_hi, cls_p, cp_q[2] > cp_q[3]);

  // midpoint sums
  assign sum_x = {lo_q[0][C-1], lo_q[0]} + {hi_q[0][C-1], hi_q[0]};
  assign sum_y = {lo_q[1][C-1], lo_q[1]} + {hi_q[1][C-1], hi_q[1]};
  assign sum_z = {lo_q[2][C-1], lo_q[2]} + {hi_q[2][C-1], hi_q[2]};

  // captured item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_point) begin
      px_q   <= point_x_i;
      py_q   <= point_y_i;
      pz_q   <= point_z_i;
      last_q <= last_point_i;
    end
  end

  // product slots
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      cp_q[cmd_i.mul_slot] <= prod;
    end
  end

  // extreme points
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      if (!started_q) begin
        lo_q[0] <= px_q;
        lo_q[1] <= py_q;
        lo_q[2] <= pz_q;
        hi_q[0] <= px_q;
        hi_q[1] <= py_q;
        hi_q[2] <= pz_q;
      end else if (less_lo) begin
        lo_q[0] <= px_q;
        lo_q[1] <= py_q;
        lo_q[2] <= pz_q;
      end else if (less_hi) begin
        hi_q[0] <= px_q;
        hi_q[1] <= py_q;
        hi_q[2] <= pz_q;
      end
    end
  end

  // cloud start flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else if (cmd_i.decide) begin
      started_q <= 1'b1;
    end else if (cmd_i.out_load) begin
      started_q <= 1'b0;
    end
  end

  // sum of squares
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_first) begin
      acc_q <= {2'b00, cp_q[0]} + {2'b00, cp_q[1]};
    end else if (cmd_i.sum_next) begin
      acc_q <= acc_q + {2'b00, cp_q[2]};
    end
  end

  pcae_isqrt #(
    .ROOT_BITS (NR)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.root_start),
    .radicand_i (acc_q),
    .busy_o     (root_busy),
    .root_o     (root)
  );

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cx_q     <= sum_x[C:1];
      cy_q     <= sum_y[C:1];
      cz_q     <= sum_z[C:1];
      height_q <= root[C:0];
    end
  end

  assign status_o.last      = last_q;
  assign status_o.root_busy = root_busy;
  assign status_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign center_x_o  = cx_q;
  assign center_y_o  = cy_q;
  assign center_z_o  = cz_q;
  assign height_o    = height_q;

`ifndef NO_ASSERTIONS
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result register overwritten before it was taken");
  a_decide_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |=> started_q)
    else $error("cloud not marked started after a point");
  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> !started_q)
    else $error("cloud state not cleared after a result");
`endif

endmodule

`default_nettype wire

/* design/pcae_ctrl.sv */
// controller: sequences compare and update for each item, then squares and root after the last
`timescale 1ns / 1ps
`default_nettype none

module pcae_ctrl
  import pcae_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_X0     = 4'd1;
  localparam logic [3:0] S_X1     = 4'd2;
  localparam logic [3:0] S_X2     = 4'd3;
  localparam logic [3:0] S_X3     = 4'd4;
  localparam logic [3:0] S_DEC    = 4'd5;
  localparam logic [3:0] S_Q0     = 4'd6;
  localparam logic [3:0] S_Q1     = 4'd7;
  localparam logic [3:0] S_Q2     = 4'd8;
  localparam logic [3:0] S_SUM0   = 4'd9;
  localparam logic [3:0] S_SUM1   = 4'd10;
  localparam logic [3:0] S_RSTART = 4'd11;
  localparam logic [3:0] S_ROOT   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_point = 1'b1;
          state_d          = S_X0;
        end
      end
      S_X0: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_op   = MUL_PY_LZ;
        cmd_o.mul_slot = SLOT_0;
        state_d        = S_X1;
      end
      S_X1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_op   = MUL_PZ_LY;
        cmd_o.mul_slot = SLOT_1;
        state_d        = S_X2;
      end
      S_X2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_op   = MUL_HY_PZ;
        cmd_o.mul_slot = SLOT_2;
        state_d        = S_X3;
      end
      S_X3: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_op   = MUL_HZ_PY;
        cmd_o.mul_slot = SLOT_3;
        state_d        = S_DEC;
      end
      S_DEC: begin
        cmd_o.decide = 1'b1;
        state_d      = status_i.last ? S_Q0 : S_IDLE;
      end
      S_Q0: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_op   = MUL_SQ_X;
        cmd_o.mul_slot = SLOT_0;
        state_d        = S_Q1;
      end
      S_Q1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_op   = MUL_SQ_Y;
        cmd_o.mul_slot = SLOT_1;
        state_d        = S_Q2;
      end
      S_Q2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_op   = MUL_SQ_Z;
        cmd_o.mul_slot = SLOT_2;
        state_d        = S_SUM0;
      end
      S_SUM0: begin
        cmd_o.sum_first = 1'b1;
        state_d         = S_SUM1;
      end
      S_SUM1: begin
        cmd_o.sum_next = 1'b1;
        state_d        = S_RSTART;
      end
      S_RSTART: begin
        cmd_o.root_start = 1'b1;
        state_d          = S_ROOT;
      end
      S_ROOT: begin
        if (!status_i.root_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* design/point_cloud_angle_extremes_top.sv */
// a point without the last mark passes the cross products and the decision; no new point
// is taken before that ends. A last point then adds the squares on the shared multiplier,
// their sum and the bit-serial square root (COORD_BITS + 2 steps) before the result loads.
// the next cloud may start while the result waits in the output register
// reset: asynchronous, active low; clears the controller, cloud flag and valids
`timescale 1ns / 1ps
`default_nettype none

module point_cloud_angle_extremes_top
  import pcae_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic signed [COORD_BITS-1:0] point_z_i,
  input  wire logic                         last_point_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0]      center_x_o,
  output logic signed [COORD_BITS-1:0]      center_y_o,
  output logic signed [COORD_BITS-1:0]      center_z_o,
  output logic [COORD_BITS:0]               height_o
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  pcae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  pcae_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .last_point_i (last_point_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .center_x_o   (center_x_o),
    .center_y_o   (center_y_o),
    .center_z_o   (center_z_o),
    .height_o     (height_o)
  );

endmodule

`default_nettype wire
